FILE: hw/rtl/canopen_frame_classifier_unit_assert.svh
// Assertion macros for the frame classifier
`ifndef CANOPEN_FRAME_CLASSIFIER_UNIT_ASSERT_SVH
`define CANOPEN_FRAME_CLASSIFIER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define CFCU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CFCU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CFCU_ASSERT_IMP(lbl, ante, cons, msg)
`define CFCU_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/cfcu_pkg.sv
`timescale 1ns / 1ps

package cfcu_pkg;

  localparam logic [3:0] KIND_IGNORED   = 4'd0;
  localparam logic [3:0] KIND_NMT       = 4'd1;
  localparam logic [3:0] KIND_SYNC      = 4'd2;
  localparam logic [3:0] KIND_EMCY      = 4'd3;
  localparam logic [3:0] KIND_TIME      = 4'd4;
  localparam logic [3:0] KIND_SDO_REQ   = 4'd5;
  localparam logic [3:0] KIND_SDO_RESP  = 4'd6;
  localparam logic [3:0] KIND_SDO_ABORT = 4'd7;
  localparam logic [3:0] KIND_HEARTBEAT = 4'd8;
  localparam logic [3:0] KIND_TPDO      = 4'd9;
  localparam logic [3:0] KIND_RPDO      = 4'd10;

  localparam logic [10:0] COB_NMT       = 11'h000;
  localparam logic [10:0] COB_SYNC      = 11'h080;
  localparam logic [10:0] COB_EMCY_LAST = 11'h0FF;
  localparam logic [10:0] COB_TIME      = 11'h100;
  localparam logic [10:0] COB_PDO_FIRST = 11'h180;
  localparam logic [10:0] COB_PDO_LAST  = 11'h57F;
  localparam logic [10:0] COB_RSP_FIRST = 11'h580;
  localparam logic [10:0] COB_RSP_LAST  = 11'h5FF;
  localparam logic [10:0] COB_REQ_FIRST = 11'h600;
  localparam logic [10:0] COB_REQ_LAST  = 11'h67F;
  localparam logic [10:0] COB_HB_FIRST  = 11'h700;
  localparam logic [10:0] COB_HB_LAST   = 11'h77F;

  localparam logic [7:0] SDO_CMD_ABORT = 8'h80;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  node_id;
    logic [2:0]  pdo_number;
    logic [7:0]  command_byte;
    logic [15:0] object_index;
    logic [7:0]  sub_index;
    logic [31:0] word_value;
    logic [15:0] days_value;
    logic        value_valid;
    logic [2:0]  value_bytes;
  } cfcu_result_t;

endpackage

FILE: hw/rtl/canopen_frame_classifier_unit.sv
`timescale 1ns / 1ps
// Throughput: one frame per cycle; busy stays low, start may be held high.
// Path: input register, one pass of compare and select logic, result register.
// Reset (synchronous, rst_n low): strobe and pipeline valid clear, decode_enable sets.
// The receiver cannot stall: out_valid lasts exactly one cycle per frame.
`include "canopen_frame_classifier_unit_assert.svh"

module canopen_frame_classifier_unit import cfcu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [10:0] in_can_id,
  input  logic        in_is_extended,
  input  logic        in_is_remote,
  input  logic [3:0]  in_byte_count,
  input  logic [63:0] in_payload,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  output logic        out_valid,
  output logic [3:0]  out_kind,
  output logic [7:0]  out_node_id,
  output logic [2:0]  out_pdo_number,
  output logic [7:0]  out_command_byte,
  output logic [15:0] out_object_index,
  output logic [7:0]  out_sub_index,
  output logic [31:0] out_word_value,
  output logic [15:0] out_days_value,
  output logic        out_value_valid,
  output logic [2:0]  out_value_bytes
);

  logic         decode_enable_r;
  logic         in_valid_r;
  logic [10:0]  id_r;
  logic         ext_r;
  logic         rtr_r;
  logic [3:0]   len_r;
  logic [63:0]  pl_r;
  logic         out_valid_r;
  cfcu_result_t res_r;
  cfcu_result_t res_nxt;

  logic [3:0]   len_sat;
  logic [7:0]   cmd;
  logic [10:0]  pdo_off;
  logic [2:0]   exp_size;
  logic [31:0]  exp_word;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_enable_r <= 1'b1;
      in_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        decode_enable_r <= cfg_data;
      end
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      id_r  <= in_can_id;
      ext_r <= in_is_extended;
      rtr_r <= in_is_remote;
      len_r <= in_byte_count;
      pl_r  <= in_payload;
    end
    if (in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  always_comb begin
    len_sat  = (len_r > 4'd8) ? 4'd8 : len_r;
    cmd      = pl_r[7:0];
    pdo_off  = id_r - COB_PDO_FIRST;
    exp_size = cmd[0] ? (3'd4 - {1'b0, cmd[3:2]}) : 3'd4;
    case (exp_size)
      3'd1:    exp_word = {24'd0, pl_r[39:32]};
      3'd2:    exp_word = {16'd0, pl_r[47:32]};
      3'd3:    exp_word = {8'd0, pl_r[55:32]};
      default: exp_word = pl_r[63:32];
    endcase

    res_nxt = '0;
    if (ext_r || rtr_r || !decode_enable_r) begin
      res_nxt = '0;
    end else if (id_r == COB_NMT && len_sat >= 4'd2) begin
      res_nxt.kind         = KIND_NMT;
      res_nxt.command_byte = pl_r[7:0];
      res_nxt.node_id      = pl_r[15:8];
    end else if (id_r == COB_SYNC) begin
      res_nxt.kind = KIND_SYNC;
    end else if (id_r > COB_SYNC && id_r <= COB_EMCY_LAST) begin
      res_nxt.kind    = KIND_EMCY;
      res_nxt.node_id = {1'b0, id_r[6:0]};
      if (len_sat >= 4'd2) begin
        res_nxt.object_index = pl_r[15:0];
      end
      if (len_sat >= 4'd3) begin
        res_nxt.sub_index = pl_r[23:16];
      end
    end else if (id_r == COB_TIME) begin
      res_nxt.kind = KIND_TIME;
      if (len_sat >= 4'd6) begin
        res_nxt.word_value  = pl_r[31:0];
        res_nxt.days_value  = pl_r[47:32];
        res_nxt.value_valid = 1'b1;
      end
    end else if (((id_r >= COB_REQ_FIRST && id_r <= COB_REQ_LAST) ||
                  (id_r >= COB_RSP_FIRST && id_r <= COB_RSP_LAST)) && len_sat >= 4'd4) begin
      res_nxt.kind         = (id_r >= COB_REQ_FIRST) ? KIND_SDO_REQ : KIND_SDO_RESP;
      res_nxt.node_id      = {1'b0, id_r[6:0]};
      res_nxt.command_byte = cmd;
      res_nxt.object_index = pl_r[23:8];
      res_nxt.sub_index    = pl_r[31:24];
      if (id_r < COB_REQ_FIRST && cmd == SDO_CMD_ABORT && len_sat == 4'd8) begin
        res_nxt.kind        = KIND_SDO_ABORT;
        res_nxt.word_value  = pl_r[63:32];
        res_nxt.value_valid = 1'b1;
      end else if (cmd[1] && len_sat == 4'd8) begin
        res_nxt.word_value  = exp_word;
        res_nxt.value_valid = 1'b1;
        res_nxt.value_bytes = exp_size;
      end
    end else if (id_r >= COB_HB_FIRST && id_r <= COB_HB_LAST && len_sat >= 4'd1) begin
      res_nxt.kind         = KIND_HEARTBEAT;
      res_nxt.node_id      = {1'b0, id_r[6:0]};
      res_nxt.command_byte = pl_r[7:0];
    end else if (id_r >= COB_PDO_FIRST && id_r <= COB_PDO_LAST) begin
      res_nxt.kind       = pdo_off[7] ? KIND_RPDO : KIND_TPDO;
      res_nxt.pdo_number = {1'b0, pdo_off[9:8]} + 3'd1;
      res_nxt.node_id    = {1'b0, pdo_off[6:0]};
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = res_r.kind;
  assign out_node_id      = res_r.node_id;
  assign out_pdo_number   = res_r.pdo_number;
  assign out_command_byte = res_r.command_byte;
  assign out_object_index = res_r.object_index;
  assign out_sub_index    = res_r.sub_index;
  assign out_word_value   = res_r.word_value;
  assign out_days_value   = res_r.days_value;
  assign out_value_valid  = res_r.value_valid;
  assign out_value_bytes  = res_r.value_bytes;

  `CFCU_ASSERT_NXT(a_start_to_result, start, ##1 out_valid,
                   "accepted frame lost in pipeline")
  `CFCU_ASSERT_NXT(a_cfg_write, cfg_valid && cfg_ready,
                   decode_enable_r == $past(cfg_data), "enable write not taken")
  `CFCU_ASSERT_IMP(a_ignored_clean, out_valid && out_kind == KIND_IGNORED,
                   out_node_id == 8'd0 && out_word_value == 32'd0 && !out_value_valid,
                   "ignored frame carries data")
  `CFCU_ASSERT_IMP(a_bytes_sdo, out_valid && out_value_bytes != 3'd0,
                   out_value_valid && (out_kind == KIND_SDO_REQ || out_kind == KIND_SDO_RESP),
                   "value bytes outside expedited SDO")
  `CFCU_ASSERT_IMP(a_pdo_number, out_valid && out_pdo_number != 3'd0,
                   out_kind == KIND_TPDO || out_kind == KIND_RPDO,
                   "PDO number on non-PDO kind")

endmodule
